### src/psc_pkg.sv
// psc_pkg: shared types and constants for the per-source packet counter.
// Used by psc_ctrl, psc_dp and the top level; no dependencies.
`timescale 1ns / 1ps

package psc_pkg;

  // Frame layout
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [5:0]  POS_MAX       = 6'd63;
  localparam logic [5:0]  POS_MIN_LAST  = 6'd33;  // last byte of a 34-byte frame
  localparam logic [5:0]  POS_ET_HI     = 6'd12;
  localparam logic [5:0]  POS_ET_LO     = 6'd13;
  localparam logic [5:0]  POS_SRC_FIRST = 6'd26;
  localparam logic [5:0]  POS_SRC_LAST  = 6'd29;
  localparam logic [5:0]  POS_DST_FIRST = 6'd30;
  localparam logic [5:0]  POS_DST_LAST  = 6'd33;

  // Result codes
  typedef enum logic [2:0] {
    OC_IGNORED  = 3'd0,
    OC_NO_MATCH = 3'd1,
    OC_COUNTED  = 3'd2,
    OC_INSERTED = 3'd3,
    OC_FULL     = 3'd4
  } outcome_t;

  // Controller to datapath
  typedef struct packed {
    logic beat;          // input beat accepted
    logic frame_end;     // accepted beat carries last
    logic load_imm;      // load result with no table action
    logic search_start;  // latch source, reset search pointer
    logic search_run;    // step the table scan
    logic commit;        // table write and result load
  } psc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_ok;      // long enough and IPv4
    logic dst_match;     // destination equals target
    logic hit;           // scan found the source
    logic miss;          // scan ran past the filled entries
  } psc_sts_t;

endpackage

### src/psc_ctrl.sv
// psc_ctrl: frame/search sequencer and result valid flag.
// Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  psc_pkg::psc_sts_t sts,
  output psc_pkg::psc_cmd_t cmd
);
  import psc_pkg::*;

  typedef enum logic [2:0] {
    S_RECV   = 3'b001,
    S_SEARCH = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   acc;

  // Result register can take a new beat this cycle
  assign out_free = !out_valid_r || !out_stall;

  // A last byte may need the result register at once
  assign in_stall = (state_r != S_RECV) || (in_last && !out_free);
  assign acc      = in_valid && !in_stall;

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    cmd              = '0;
    cmd.beat         = acc;
    cmd.frame_end    = acc && in_last;
    case (state_r)
      S_RECV: begin
        if (acc && in_last) begin
          if (sts.frame_ok && sts.dst_match) begin
            cmd.search_start = 1'b1;
            state_nxt        = S_SEARCH;
          end else begin
            cmd.load_imm = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        cmd.search_run = 1'b1;
        if (sts.hit || sts.miss) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_RECV;
        end
      end
      default: state_nxt = S_RECV;
    endcase
  end

  // Result valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.load_imm || cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RECV;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### src/psc_dp.sv
// psc_dp: header capture, source table (key/count memories, fill count),
// scan pointer and result registers. Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_dp #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_data_byte,
  input  logic              cfg_write_en,
  input  logic [31:0]       cfg_target_address,
  input  psc_pkg::psc_cmd_t cmd,
  output psc_pkg::psc_sts_t sts,
  output logic [2:0]        out_outcome,
  output logic [31:0]       out_source_address,
  output logic [31:0]       out_hit_count,
  output logic [6:0]        out_slot
);
  import psc_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_FILL = CW'(TABLE_ENTRIES);

  // Config and frame capture
  logic [31:0] target_r;
  logic [5:0]  pos_r, pos_nxt;
  logic [15:0] et_r, et_cap;
  logic [31:0] src_r, src_cap;
  logic [31:0] dst_r, dst_cap;

  // Table and scan
  logic [31:0]   key_mem [TABLE_ENTRIES];
  logic [31:0]   cnt_mem [TABLE_ENTRIES];
  logic [CW-1:0] fill_r;
  logic [CW-1:0] idx_r;
  logic [31:0]   key_r;
  logic          rd_en;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic [31:0]   rd_key_r;
  logic [31:0]   rd_cnt_r;
  logic          found_r;
  logic [AW-1:0] hit_idx_r;
  logic [31:0]   new_cnt_r;
  logic          has_room;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_cnt;

  // Result registers
  outcome_t    oc_r, oc_nxt;
  logic [31:0] res_src_r, res_src_nxt;
  logic [31:0] res_cnt_r, res_cnt_nxt;
  logic [6:0]  res_slot_r, res_slot_nxt;

  // Field capture including the byte on the wire
  always_comb begin
    et_cap  = et_r;
    src_cap = src_r;
    dst_cap = dst_r;
    if (pos_r == POS_ET_HI || pos_r == POS_ET_LO)
      et_cap = {et_r[7:0], in_data_byte};
    else if (pos_r inside {[POS_SRC_FIRST:POS_SRC_LAST]})
      src_cap = {src_r[23:0], in_data_byte};
    else if (pos_r inside {[POS_DST_FIRST:POS_DST_LAST]})
      dst_cap = {dst_r[23:0], in_data_byte};
  end

  assign pos_nxt = (pos_r < POS_MAX) ? pos_r + 6'd1 : pos_r;

  assign sts.frame_ok  = (pos_r >= POS_MIN_LAST) && (et_cap == ETH_TYPE_IPV4);
  assign sts.dst_match = (dst_cap == target_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      pos_r    <= '0;
      et_r     <= '0;
      src_r    <= '0;
      dst_r    <= '0;
    end else begin
      if (cfg_write_en) target_r <= cfg_target_address;
      if (cmd.frame_end) begin
        pos_r <= '0;
        et_r  <= '0;
        src_r <= '0;
        dst_r <= '0;
      end else if (cmd.beat) begin
        pos_r <= pos_nxt;
        et_r  <= et_cap;
        src_r <= src_cap;
        dst_r <= dst_cap;
      end
    end
  end

  // Scan: one key read per cycle over the filled prefix
  assign rd_en    = cmd.search_run && (idx_r < fill_r);
  assign sts.hit  = cmd.search_run && rd_vld_r && (rd_key_r == key_r);
  assign sts.miss = cmd.search_run && !rd_vld_r && (idx_r >= fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      idx_r    <= '0;
    end else if (cmd.search_start) begin
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      idx_r    <= '0;
    end else if (cmd.search_run) begin
      rd_vld_r <= rd_en;
      if (rd_en) idx_r <= idx_r + CW'(1);
      if (sts.hit) found_r <= 1'b1;
    end
  end

  // Scan payload
  always_ff @(posedge clk) begin
    if (cmd.search_start) key_r <= src_cap;
    if (rd_en) rd_idx_r <= idx_r[AW-1:0];
    if (sts.hit) begin
      hit_idx_r <= rd_idx_r;
      new_cnt_r <= rd_cnt_r + 32'd1;
    end
  end

  // Table memories
  assign has_room = (fill_r != FULL_FILL);
  assign wr_en    = cmd.commit && (found_r || has_room);
  assign wr_addr  = found_r ? hit_idx_r : fill_r[AW-1:0];
  assign wr_cnt   = found_r ? new_cnt_r : 32'd1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= key_r;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[idx_r[AW-1:0]];
      rd_cnt_r <= cnt_mem[idx_r[AW-1:0]];
    end
  end

  // Fill count: valid entries are always the low prefix
  always_ff @(posedge clk) begin
    if (!rst_n)
      fill_r <= '0;
    else if (cmd.commit && !found_r && has_room)
      fill_r <= fill_r + CW'(1);
  end

  // Result selection
  always_comb begin
    oc_nxt       = oc_r;
    res_src_nxt  = res_src_r;
    res_cnt_nxt  = res_cnt_r;
    res_slot_nxt = res_slot_r;
    if (cmd.load_imm) begin
      res_cnt_nxt  = '0;
      res_slot_nxt = '0;
      if (!sts.frame_ok) begin
        oc_nxt      = OC_IGNORED;
        res_src_nxt = '0;
      end else begin
        oc_nxt      = OC_NO_MATCH;
        res_src_nxt = src_cap;
      end
    end else if (cmd.commit) begin
      res_src_nxt = key_r;
      if (found_r) begin
        oc_nxt       = OC_COUNTED;
        res_cnt_nxt  = new_cnt_r;
        res_slot_nxt = 7'(hit_idx_r);
      end else if (has_room) begin
        oc_nxt       = OC_INSERTED;
        res_cnt_nxt  = 32'd1;
        res_slot_nxt = 7'(fill_r[AW-1:0]);
      end else begin
        oc_nxt       = OC_FULL;
        res_cnt_nxt  = '0;
        res_slot_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    oc_r       <= oc_nxt;
    res_src_r  <= res_src_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_slot_r <= res_slot_nxt;
  end

  assign out_outcome        = oc_r;
  assign out_source_address = res_src_r;
  assign out_hit_count      = res_cnt_r;
  assign out_slot           = res_slot_r;

endmodule

### src/per_source_packet_counter.sv
// per_source_packet_counter: top level, controller plus datapath.
// Depends on psc_pkg, psc_ctrl and psc_dp.
//
//   port group   dir  handshake            payload
//   in_*         in   in_valid / in_stall  in_data_byte[7:0], in_last
//   out_*        out  out_valid / out_stall out_outcome[2:0], out_source_address[31:0],
//                                          out_hit_count[31:0], out_slot[6:0]
//   cfg_*        in   cfg_write_en         cfg_target_address[31:0]
//
// One byte per cycle while receiving. A last byte of an IPv4 frame to the
// target starts a table scan that reads one key per cycle from the key
// memory over the F filled entries; input is held through the scan and
// until the result is loaded, which waits for a stalled result register.
// Other last bytes load the result directly; a last byte waits while the
// result register is full and stalled. Reset empties the table at once
// (fill count), so there is no clearing pass.
`timescale 1ns / 1ps

module per_source_packet_counter #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_outcome,
  output logic [31:0] out_source_address,
  output logic [31:0] out_hit_count,
  output logic [6:0]  out_slot,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_target_address
);
  import psc_pkg::*;

  psc_cmd_t cmd;
  psc_sts_t sts;

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  psc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_data_byte       (in_data_byte),
    .cfg_write_en       (cfg_write_en),
    .cfg_target_address (cfg_target_address),
    .cmd                (cmd),
    .sts                (sts),
    .out_outcome        (out_outcome),
    .out_source_address (out_source_address),
    .out_hit_count      (out_hit_count),
    .out_slot           (out_slot)
  );

endmodule
